// ===== hdl/ufbd_pkg.sv =====
package ufbd_pkg;

	localparam int PCLK_W   = 26;
	localparam int BAUD_W   = 22;
	localparam int DL_W     = 16;
	localparam int NIB_W    = 4;
	localparam int BASE_W   = BAUD_W + 4;
	localparam int NUM10_W  = PCLK_W + 4;
	localparam int DIVR_W   = BASE_W + 5;
	localparam int QEX_W    = 22;
	localparam int CAND_W   = 23;
	localparam int DEN_W    = 27;
	localparam int PROD_W   = BASE_W + CAND_W;
	localparam int CHK_W    = 32;
	localparam int STEP_W   = 6;
	localparam int EST_W    = 4;
	localparam int N_EST    = 10;
	localparam int M_LAST   = 15;
	localparam int DL_MAX   = 65535;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic [PCLK_W-1:0] pclk_hz;
		logic [BAUD_W-1:0] baud_rate;
	} req_t;

	typedef struct packed {
		logic [DL_W-1:0]  divisor_latch;
		logic [NIB_W-1:0] div_add;
		logic [NIB_W-1:0] mul_val;
		status_t          status;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EX_GO,
		S_EX_WAIT,
		S_ES_GO,
		S_ES_WAIT,
		S_ES_MUL,
		S_ES_CHK,
		S_FR_GO,
		S_FR_WAIT,
		S_SR_GO,
		S_SR_WAIT,
		S_DONE
	} state_t;

	// fraction estimate in tenths: 1.5 first, then 1.1 .. 1.9
	function automatic logic [4:0] est_tenths(input logic [EST_W-1:0] idx);
		logic [4:0] t;
		if (idx == '0) begin
			t = 5'd15;
		end else begin
			t = 5'd10 + 5'(idx);
		end
		return t;
	endfunction

endpackage

// ===== hdl/uart_fractional_baud_divider.sv =====
// Computes UART divider settings from a peripheral clock and a baud rate: a 16-bit divisor
// latch plus a div_add/mul_val fractional pair, with status 0 ok, 1 no fraction in 1.1..1.9,
// 2 divisor zero or above 65535 (also for a zero baud rate). One request at a time; a new
// request is taken while the previous result waits in the output register. All divisions run
// through one shared restoring divider at one quotient bit per cycle. When the clock is an
// exact multiple of 16 x baud one division gives the divisor; otherwise fraction estimates
// are tried in turn (1 to 10), then come the fraction division and the 15-step mul_val
// search.
module uart_fractional_baud_divider #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ufbd_pkg::req_t  req_data,
	output logic            res_valid,
	input  logic            res_ready,
	output ufbd_pkg::res_t  res_data
);
	import ufbd_pkg::*;

	localparam int NW = PCLK_W + FRAC_BITS;

	state_t              state_q;
	state_t              state_nx;

	logic [PCLK_W-1:0]   pclk_q;
	logic [BASE_W-1:0]   base_q;
	logic [EST_W-1:0]    idx_q;
	logic [CAND_W-1:0]   cand_q;
	logic [DEN_W-1:0]    den_q;
	logic [DL_W-1:0]     dl_q;
	logic [NIB_W-1:0]    add_q;
	logic [NIB_W-1:0]    mul_q;
	status_t             st_q;
	res_t                res_q;
	logic                res_valid_q;

	div_ctl_t            div_ctl;
	div_sts_t            div_sts;
	logic [NW-1:0]       div_num;
	logic [DIVR_W-1:0]   div_den;
	logic [NW-1:0]       div_quo;
	logic [DIVR_W-1:0]   div_rem;

	logic                sr_start;
	logic                sr_done;
	logic [3:0]          sr_add;
	logic [3:0]          sr_mul;

	logic                acc;
	logic                out_free;
	logic                est_last;
	logic [NUM10_W-1:0]  pclk10;
	logic [CHK_W-1:0]    chk_num;
	logic [CHK_W-1:0]    chk_lo;
	logic [CHK_W-1:0]    chk_hi;
	logic                fits;
	logic [CAND_W-1:0]   q_cand;
	logic [QEX_W-1:0]    q_ex;
	logic [PROD_W-1:0]   den_w;

	always_comb begin
		acc      = req_valid && req_ready;
		out_free = !res_valid_q || res_ready;
		est_last = (idx_q == EST_W'(N_EST - 1));
		pclk10   = NUM10_W'({pclk_q, 3'b000}) + NUM10_W'({pclk_q, 1'b0});
		chk_num  = CHK_W'(pclk10);
		chk_lo   = (CHK_W'(den_q) << 3) + (CHK_W'(den_q) << 1) + CHK_W'(den_q);
		chk_hi   = (CHK_W'(den_q) << 4) + (CHK_W'(den_q) << 1) + CHK_W'(den_q);
		fits     = (chk_num >= chk_lo) && (chk_num <= chk_hi);
		q_cand   = div_quo[CAND_W-1:0];
		q_ex     = div_quo[QEX_W-1:0];
		den_w    = PROD_W'(base_q) * PROD_W'(cand_q);
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					state_nx = (req_data.baud_rate == '0) ? S_DONE : S_EX_GO;
				end
			end
			S_EX_GO:   state_nx = S_EX_WAIT;
			S_EX_WAIT: begin
				if (div_sts.done) begin
					state_nx = (div_rem == '0) ? S_DONE : S_ES_GO;
				end
			end
			S_ES_GO:   state_nx = S_ES_WAIT;
			S_ES_WAIT: begin
				if (div_sts.done) begin
					if (q_cand != '0) begin
						state_nx = S_ES_MUL;
					end else begin
						state_nx = est_last ? S_DONE : S_ES_GO;
					end
				end
			end
			S_ES_MUL:  state_nx = S_ES_CHK;
			S_ES_CHK: begin
				if (fits) begin
					state_nx = (cand_q > CAND_W'(DL_MAX)) ? S_DONE : S_FR_GO;
				end else begin
					state_nx = est_last ? S_DONE : S_ES_GO;
				end
			end
			S_FR_GO:   state_nx = S_FR_WAIT;
			S_FR_WAIT: begin
				if (div_sts.done) begin
					state_nx = S_SR_GO;
				end
			end
			S_SR_GO:   state_nx = S_SR_WAIT;
			S_SR_WAIT: begin
				if (sr_done) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready     = 1'b0;
		sr_start      = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.steps = STEP_W'(NW);
		div_num       = {pclk_q, {FRAC_BITS{1'b0}}};
		div_den       = DIVR_W'(den_q);
		unique case (state_q)
			S_IDLE:  req_ready = 1'b1;
			S_EX_GO: begin
				div_ctl.start = 1'b1;
				div_ctl.steps = STEP_W'(PCLK_W);
				div_den       = DIVR_W'(base_q);
			end
			S_ES_GO: begin
				div_ctl.start = 1'b1;
				div_ctl.steps = STEP_W'(NUM10_W);
				div_num       = {pclk10, {(NW - NUM10_W){1'b0}}};
				div_den       = DIVR_W'(base_q) * DIVR_W'(est_tenths(idx_q));
			end
			S_FR_GO: div_ctl.start = 1'b1;
			S_SR_GO: sr_start = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					pclk_q <= req_data.pclk_hz;
					base_q <= {req_data.baud_rate, 4'b0000};
					idx_q  <= '0;
					dl_q   <= '0;
					add_q  <= '0;
					mul_q  <= NIB_W'(1);
					st_q   <= (req_data.baud_rate == '0) ? ST_RANGE : ST_OK;
				end
			end
			S_EX_WAIT: begin
				if (div_sts.done && div_rem == '0) begin
					if (q_ex == '0 || q_ex > QEX_W'(DL_MAX)) begin
						st_q <= ST_RANGE;
					end else begin
						dl_q <= q_ex[DL_W-1:0];
					end
				end
			end
			S_ES_WAIT: begin
				if (div_sts.done) begin
					cand_q <= q_cand;
					if (q_cand == '0) begin
						idx_q <= idx_q + EST_W'(1);
						if (est_last) begin
							st_q <= ST_NOFIT;
						end
					end
				end
			end
			S_ES_MUL: den_q <= den_w[DEN_W-1:0];
			S_ES_CHK: begin
				if (fits) begin
					if (cand_q > CAND_W'(DL_MAX)) begin
						st_q <= ST_RANGE;
					end else begin
						dl_q <= cand_q[DL_W-1:0];
					end
				end else begin
					idx_q <= idx_q + EST_W'(1);
					if (est_last) begin
						st_q <= ST_NOFIT;
					end
				end
			end
			S_SR_WAIT: begin
				if (sr_done) begin
					add_q <= sr_add;
					mul_q <= sr_mul;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			res_q.divisor_latch <= dl_q;
			res_q.div_add       <= add_q;
			res_q.mul_val       <= mul_q;
			res_q.status        <= st_q;
		end
	end

	ufbd_div #(
		.NW (NW),
		.DW (DIVR_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.sts    (div_sts),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	ufbd_search #(
		.FRAC_BITS (FRAC_BITS)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sr_start),
		.f      (div_quo[FRAC_BITS-1:0]),
		.done   (sr_done),
		.add    (sr_add),
		.mul    (sr_mul)
	);

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != ST_OK) |->
		(res_q.divisor_latch == '0 && res_q.div_add == '0 && res_q.mul_val == NIB_W'(1)))
		else $error("faulted result carries nonzero settings");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_OK) |->
		(res_q.divisor_latch != '0 && res_q.mul_val != '0))
		else $error("ok result with zero divisor or multiplier");

	a_frac_dl: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FR_GO) |-> (dl_q != '0 && st_q == ST_OK))
		else $error("fraction division started without a divisor");

endmodule

// ===== hdl/ufbd_div.sv =====
module ufbd_div #(
	parameter int NW = 42,
	parameter int DW = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ufbd_pkg::div_ctl_t ctl,
	input  logic [NW-1:0]      num,
	input  logic [DW-1:0]      den,
	output ufbd_pkg::div_sts_t sts,
	output logic [NW-1:0]      quo,
	output logic [DW-1:0]      rem
);
	import ufbd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NW-1:0]     num_q;
	logic [NW-1:0]     quo_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     den_q;

	logic [DW:0]       r2;
	logic [DW:0]       diff;
	logic              ge;
	logic [DW-1:0]     rem_nx;

	// restoring division, one quotient bit per cycle
	always_comb begin
		r2     = {rem_q, num_q[NW-1]};
		diff   = r2 - {1'b0, den_q};
		ge     = (r2 >= {1'b0, den_q});
		rem_nx = ge ? diff[DW-1:0] : r2[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctl.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = quo_q;
	assign rem      = rem_q;

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && cnt_q == '0))
		else $error("divider busy with no steps left");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

endmodule

// ===== hdl/ufbd_search.sv =====
module ufbd_search #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [FRAC_BITS-1:0] f,
	output logic                 done,
	output logic [3:0]           add,
	output logic [3:0]           mul
);
	import ufbd_pkg::*;

	localparam int PW = FRAC_BITS + 4;

	logic                 busy_q;
	logic                 done_q;
	logic [3:0]           m_q;
	logic [3:0]           best_add_q;
	logic [3:0]           best_mul_q;
	logic [PW-1:0]        p_q;
	logic [FRAC_BITS-1:0] f_q;
	logic [FRAC_BITS-1:0] eb_q;

	logic [4:0]           add_w;
	logic [3:0]           cand_add;
	logic [PW-1:0]        tgt;
	logic [PW-1:0]        e_full;
	logic [FRAC_BITS-1:0] e_new;
	logic [PW-1:0]        lhs;
	logic [PW-1:0]        rhs;
	logic                 better;

	// p_q = f * m; errors compared cross-multiplied, each error times the other's denominator
	always_comb begin
		add_w    = {1'b0, p_q[PW-1:FRAC_BITS]} + 5'(p_q[FRAC_BITS-1]);
		cand_add = add_w[3:0];
		tgt      = {cand_add, {FRAC_BITS{1'b0}}};
		e_full   = (p_q >= tgt) ? (p_q - tgt) : (tgt - p_q);
		e_new    = e_full[FRAC_BITS-1:0];
		lhs      = PW'(e_new) * PW'(best_mul_q);
		rhs      = PW'(eb_q) * PW'(m_q);
		better   = (lhs < rhs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			m_q        <= 4'd1;
			best_add_q <= '0;
			best_mul_q <= 4'd1;
		end else if (start) begin
			busy_q     <= 1'b1;
			done_q     <= 1'b0;
			m_q        <= 4'd1;
			best_add_q <= '0;
			best_mul_q <= 4'd1;
		end else if (busy_q) begin
			if (better) begin
				best_add_q <= cand_add;
				best_mul_q <= m_q;
			end
			m_q <= m_q + 4'd1;
			if (m_q == 4'(M_LAST)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			f_q  <= f;
			p_q  <= PW'(f);
			eb_q <= f;
		end else if (busy_q) begin
			p_q <= p_q + PW'(f_q);
			if (better) begin
				eb_q <= e_new;
			end
		end
	end

	assign done = done_q;
	assign add  = best_add_q;
	assign mul  = best_mul_q;

endmodule
